// ===== src/lcv_pkg.sv =====
// Shared types and constants for the line clip to viewport block.
`timescale 1ns / 1ps

package lcv_pkg;

	localparam int COORD_W  = 32;
	localparam int PIX_W    = 16;
	localparam int OUT_W    = 10;
	localparam int FRAME_W  = 11;
	localparam int SCALE_W  = 31;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_W    = 33;
	localparam int CLIP_STEPS_MAX = 16;

	// register indices
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H    = 3'd6;

	// outcode bits
	localparam logic [3:0] OC_LEFT   = 4'b0001;
	localparam logic [3:0] OC_RIGHT  = 4'b0010;
	localparam logic [3:0] OC_BOTTOM = 4'b0100;
	localparam logic [3:0] OC_TOP    = 4'b1000;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic             visible;
		logic [OUT_W-1:0] pix_start_x;
		logic [OUT_W-1:0] pix_start_y;
		logic [OUT_W-1:0] pix_end_x;
		logic [OUT_W-1:0] pix_end_y;
	} out_item_t;

	typedef struct packed {
		logic                      start;
		logic signed [COORD_W-1:0] num;
		logic signed [PIX_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/line_clip_to_viewport_unit.sv =====
// Top level: sequencer for map window test, pixel mapping and line clipping.
// Work runs in order: the window test, mapping of the four coordinates, then
// the clip steps (up to 16 steps), and the hand-over of the result.
// One item at a time: a new segment is taken only when idle, and each clip
// step adds a pass of the shared divider.
// Reset (arst_n low) clears the sequencer, the result slot and the configuration registers
// to their defaults: window 0, scale 13107, frame 240 by 160.
`timescale 1ns / 1ps

module line_clip_to_viewport_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lcv_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lcv_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [lcv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcv_pkg::COORD_W-1:0]     cfg_data
);
	import lcv_pkg::*;

	localparam int STEP_W = $clog2(CLIP_STEPS_MAX + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_WIN, S_MSUB, S_MMUL, S_MCAP, S_OUTC,
		S_CSET, S_CMUL, S_CDIVS, S_CDIVW, S_CUPD, S_DONE
	} state_t;

	// outcode in pixel space
	function automatic logic [3:0] pix_oc(input logic signed [PIX_W-1:0] x,
			input logic signed [PIX_W-1:0] y,
			input logic [FRAME_W-1:0] w, input logic [FRAME_W-1:0] h);
		logic [3:0] oc;
		oc = '0;
		if (y[PIX_W-1]) oc = oc | OC_TOP;
		else if (y >= {{(PIX_W-FRAME_W){1'b0}}, h}) oc = oc | OC_BOTTOM;
		if (x[PIX_W-1]) oc = oc | OC_LEFT;
		else if (x >= {{(PIX_W-FRAME_W){1'b0}}, w}) oc = oc | OC_RIGHT;
		return oc;
	endfunction

	// configuration registers
	logic signed [COORD_W-1:0] win_left_q, win_bottom_q, win_right_q, win_top_q;
	logic [SCALE_W-1:0]        scale_q;
	logic [FRAME_W-1:0]        frame_w_q, frame_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_bottom_q <= '0;
			win_right_q  <= '0;
			win_top_q    <= '0;
			scale_q      <= SCALE_W'(13107);
			frame_w_q    <= FRAME_W'(240);
			frame_h_q    <= FRAME_W'(160);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIN_LEFT:   win_left_q   <= cfg_data;
				CFG_WIN_BOTTOM: win_bottom_q <= cfg_data;
				CFG_WIN_RIGHT:  win_right_q  <= cfg_data;
				CFG_WIN_TOP:    win_top_q    <= cfg_data;
				CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				CFG_FRAME_W:    frame_w_q    <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_H:    frame_h_q    <= cfg_data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	state_t                    state_q;
	in_item_t                  seg_q;
	logic [1:0]                k_q;
	logic signed [COORD_W-1:0] d_q;
	logic signed [PIX_W-1:0]   p_q [4];
	logic [STEP_W-1:0]         step_q;
	logic                      visible_q;
	logic                      out_valid_q;
	out_item_t                 out_q;

	// clip step operands
	logic signed [PIX_W:0]     fac_q;
	logic signed [PIX_W-1:0]   mcand_q;
	logic signed [PIX_W-1:0]   den_q;
	logic signed [PIX_W-1:0]   base_q;
	logic signed [PIX_W-1:0]   fixed_q;
	logic                      vert_q;

	// shared units
	logic                          mul_en;
	logic signed [MUL_W-1:0]       mul_a, mul_b;
	logic signed [2*MUL_W-1:0]     prod_q;
	div_req_t                      dreq;
	div_rsp_t                      drsp;

	lcv_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	lcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// map window outcodes
	logic [3:0] wc1, wc2;
	always_comb begin
		wc1 = '0;
		wc2 = '0;
		if (seg_q.start_y > win_top_q) wc1 = wc1 | OC_TOP;
		else if (seg_q.start_y < win_bottom_q) wc1 = wc1 | OC_BOTTOM;
		if (seg_q.end_y > win_top_q) wc2 = wc2 | OC_TOP;
		else if (seg_q.end_y < win_bottom_q) wc2 = wc2 | OC_BOTTOM;
		if (seg_q.start_x < win_left_q) wc1 = wc1 | OC_LEFT;
		else if (seg_q.start_x > win_right_q) wc1 = wc1 | OC_RIGHT;
		if (seg_q.end_x < win_left_q) wc2 = wc2 | OC_LEFT;
		else if (seg_q.end_x > win_right_q) wc2 = wc2 | OC_RIGHT;
	end

	// pixel outcodes
	logic [3:0] c1, c2, cout;
	always_comb begin
		c1   = pix_oc(p_q[0], p_q[1], frame_w_q, frame_h_q);
		c2   = pix_oc(p_q[2], p_q[3], frame_w_q, frame_h_q);
		cout = (c1 != '0) ? c1 : c2;
	end

	// coordinate and origin for the mapping step
	logic signed [COORD_W-1:0] map_coord, map_origin;
	always_comb begin
		case (k_q)
			2'd0:    map_coord = seg_q.start_x;
			2'd1:    map_coord = seg_q.start_y;
			2'd2:    map_coord = seg_q.end_x;
			default: map_coord = seg_q.end_y;
		endcase
		map_origin = k_q[0] ? win_bottom_q : win_left_q;
	end

	// mapped term and row
	logic signed [PIX_W-1:0] term, row;
	always_comb begin
		term = prod_q[2*PIX_W+PIX_W-1:2*PIX_W];
		row  = {{(PIX_W-FRAME_W){1'b0}}, frame_h_q} - term;
	end

	// multiplier operand select and divider request
	always_comb begin
		mul_en = (state_q == S_MMUL) || (state_q == S_CMUL);
		if (state_q == S_MMUL) begin
			mul_a = {d_q[COORD_W-1], d_q};
			mul_b = {{(MUL_W-SCALE_W){1'b0}}, scale_q};
		end else begin
			mul_a = {{(MUL_W-PIX_W-1){fac_q[PIX_W]}}, fac_q};
			mul_b = {{(MUL_W-PIX_W){mcand_q[PIX_W-1]}}, mcand_q};
		end
		dreq.start = (state_q == S_CDIVS);
		dreq.num   = prod_q[COORD_W-1:0];
		dreq.den   = den_q;
	end

	// clip step setup terms
	logic signed [PIX_W-1:0] dy_tb, dy_lr, dx, w_m1, h_m1;
	logic signed [PIX_W:0]   p0_x, p1_x, w_x, h_x;
	always_comb begin
		dy_tb = p_q[1] - p_q[3];
		dy_lr = p_q[3] - p_q[1];
		dx    = p_q[2] - p_q[0];
		w_m1  = {{(PIX_W-FRAME_W){1'b0}}, frame_w_q} - 1'b1;
		h_m1  = {{(PIX_W-FRAME_W){1'b0}}, frame_h_q} - 1'b1;
		p0_x  = {p_q[0][PIX_W-1], p_q[0]};
		p1_x  = {p_q[1][PIX_W-1], p_q[1]};
		w_x   = {{(PIX_W+1-FRAME_W){1'b0}}, frame_w_q};
		h_x   = {{(PIX_W+1-FRAME_W){1'b0}}, frame_h_q};
	end

	logic signed [PIX_W-1:0] new_val;
	assign new_val = base_q + drsp.quo;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			k_q         <= '0;
			step_q      <= '0;
			visible_q   <= 1'b0;
		end else begin
			// result taken; the done state reloads the slot itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						seg_q   <= in_item;
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					k_q    <= '0;
					step_q <= '0;
					if ((wc1 & wc2) != '0) begin
						visible_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_MSUB;
					end
				end
				S_MSUB: begin
					d_q     <= map_coord - map_origin;
					state_q <= S_MMUL;
				end
				S_MMUL: begin
					state_q <= S_MCAP;
				end
				S_MCAP: begin
					p_q[k_q] <= k_q[0] ? row : term;
					k_q      <= k_q + 1'b1;
					state_q  <= (k_q == 2'd3) ? S_OUTC : S_MSUB;
				end
				S_OUTC: begin
					if ((c1 & c2) != '0) begin
						visible_q <= 1'b0;
						state_q   <= S_DONE;
					end else if ((c1 | c2) == '0) begin
						visible_q <= 1'b1;
						state_q   <= S_DONE;
					end else if (step_q >= STEP_W'(CLIP_STEPS_MAX)) begin
						visible_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_CSET;
					end
				end
				S_CSET: begin
					if ((cout & (OC_TOP | OC_BOTTOM)) != '0) begin
						vert_q  <= 1'b1;
						mcand_q <= dx;
						den_q   <= dy_tb;
						base_q  <= p_q[0];
						if ((cout & OC_TOP) != '0) begin
							fac_q   <= p1_x;
							fixed_q <= '0;
						end else begin
							fac_q   <= p1_x - h_x;
							fixed_q <= h_m1;
						end
					end else begin
						vert_q  <= 1'b0;
						mcand_q <= dy_lr;
						den_q   <= dx;
						base_q  <= p_q[1];
						if ((cout & OC_RIGHT) != '0) begin
							fac_q   <= w_x - 1'b1 - p0_x;
							fixed_q <= w_m1;
						end else begin
							fac_q   <= -p0_x;
							fixed_q <= '0;
						end
					end
					state_q <= S_CMUL;
				end
				S_CMUL: begin
					state_q <= S_CDIVS;
				end
				S_CDIVS: begin
					state_q <= S_CDIVW;
				end
				S_CDIVW: begin
					if (drsp.done) begin
						state_q <= S_CUPD;
					end
				end
				S_CUPD: begin
					// top or bottom edge fixes the row, otherwise the column
					if (c1 != '0) begin
						p_q[0] <= vert_q ? new_val : fixed_q;
						p_q[1] <= vert_q ? fixed_q : new_val;
					end else begin
						p_q[2] <= vert_q ? new_val : fixed_q;
						p_q[3] <= vert_q ? fixed_q : new_val;
					end
					step_q  <= step_q + 1'b1;
					state_q <= S_OUTC;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (visible_q) begin
							out_q.visible     <= 1'b1;
							out_q.pix_start_x <= p_q[0][OUT_W-1:0];
							out_q.pix_start_y <= p_q[1][OUT_W-1:0];
							out_q.pix_end_x   <= p_q[2][OUT_W-1:0];
							out_q.pix_end_y   <= p_q[3][OUT_W-1:0];
						end else begin
							out_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== src/lcv_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module lcv_mul (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [lcv_pkg::MUL_W-1:0]   a,
	input  logic signed [lcv_pkg::MUL_W-1:0]   b,
	output logic signed [2*lcv_pkg::MUL_W-1:0] prod_q
);
	import lcv_pkg::*;

	// product register, no reset needed
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== src/lcv_div.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
`timescale 1ns / 1ps

module lcv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lcv_pkg::div_req_t req,
	output lcv_pkg::div_rsp_t rsp
);
	import lcv_pkg::*;

	localparam int CNT_W = $clog2(COORD_W);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_t;

	dstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] num_q;
	logic [PIX_W-1:0]   den_q;
	logic [PIX_W:0]     rem_q;
	logic [COORD_W-1:0] quo_q;
	logic               neg_q;
	logic               zero_q;

	logic [PIX_W:0]     rem_sh;
	logic               fits;
	logic [COORD_W-1:0] num_mag;
	logic [PIX_W-1:0]   den_mag;
	logic [COORD_W-1:0] quo_signed;

	// magnitudes of the operands
	always_comb begin
		num_mag = req.num[COORD_W-1] ? (~req.num + 1'b1) : req.num;
		den_mag = req.den[PIX_W-1] ? (~req.den + 1'b1) : req.den;
	end

	// restoring step
	always_comb begin
		rem_sh = {rem_q[PIX_W-1:0], num_q[COORD_W-1]};
		fits   = (rem_sh >= {1'b0, den_q});
	end

	always_comb begin
		quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
		rsp.done   = (state_q == D_DONE);
		rsp.quo    = zero_q ? '0 : quo_signed[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						num_q   <= num_mag;
						den_q   <= den_mag;
						rem_q   <= '0;
						quo_q   <= '0;
						neg_q   <= req.num[COORD_W-1] ^ req.den[PIX_W-1];
						zero_q  <= (req.den == '0);
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
					quo_q <= {quo_q[COORD_W-2:0], fits};
					num_q <= {num_q[COORD_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COORD_W - 1)) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

endmodule
